// ===== rtl/core/sfp_pkg.sv =====
// shared types, constants and crc function of the sync frame parser
package sfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CRC_W       = 16;
    localparam int MAX_PAYLOAD = 8;
    localparam int STORE_DEPTH = 8;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PAYLOAD_W   = BYTE_W * STORE_DEPTH;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'h0000;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0]    frame_type;
        logic [LEN_W-1:0]     frame_len;
        logic [PAYLOAD_W-1:0] frame_payload;
    } t_frame;

    // reflected crc-16, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sfp_in_if.sv =====
// byte stream channel into the frame parser
interface sfp_in_if;
    logic                        valid;
    logic                        ready;
    logic [sfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfp_out_if.sv =====
// validated frame channel out of the frame parser
interface sfp_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfp_pkg::BYTE_W-1:0]     frame_type;
    logic [sfp_pkg::LEN_W-1:0]      frame_len;
    logic [sfp_pkg::PAYLOAD_W-1:0]  frame_payload;

    modport source (output valid, output frame_type, output frame_len,
                    output frame_payload, input ready);
    modport sink   (input valid, input frame_type, input frame_len,
                    input frame_payload, output ready);
endinterface

// ===== rtl/core/sfp_parser.sv =====
// parse state machine, payload store and running crc, one byte per step
module sfp_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [sfp_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_hit,
    output sfp_pkg::t_frame            o_frame
);
    import sfp_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [BYTE_W-1:0]       r_held_type, n_held_type;
    logic [LEN_W-1:0]        r_held_len, n_held_len;
    logic [LEN_W-1:0]        r_byte_index, n_byte_index;
    logic [BYTE_W-1:0]       r_crc_low, n_crc_low;
    logic [CRC_W-1:0]        r_crc, n_crc;
    logic [BYTE_W-1:0]       r_store [STORE_DEPTH];
    logic                    w_store_we;
    logic [CRC_W-1:0]        w_crc_upd;
    logic                    w_crc_match;

    assign w_crc_upd   = crc_step((r_phase == PH_TYPE) ? CRC_INIT : r_crc, i_byte);
    assign w_crc_match = ({i_byte, r_crc_low} == r_crc);

    // next state
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            case (r_phase)
                PH_HUNT:    n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                PH_SYNC2: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_phase = PH_TYPE;
                    end else if (i_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_TYPE:    n_phase = PH_LEN;
                PH_LEN: begin
                    if (i_byte > BYTE_W'(MAX_PAYLOAD)) begin
                        n_phase = PH_HUNT;
                    end else if (i_byte == '0) begin
                        n_phase = PH_CRC_LO;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if ((r_byte_index + 1'b1) >= r_held_len) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:  n_phase = PH_CRC_HI;
                PH_CRC_HI:  n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    // datapath updates and result
    always_comb begin
        n_held_type  = r_held_type;
        n_held_len   = r_held_len;
        n_byte_index = r_byte_index;
        n_crc_low    = r_crc_low;
        n_crc        = r_crc;
        w_store_we   = 1'b0;
        o_hit        = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_TYPE: begin
                    n_held_type = i_byte;
                    n_crc       = w_crc_upd;
                end
                PH_LEN: begin
                    n_byte_index = '0;
                    if (i_byte <= BYTE_W'(MAX_PAYLOAD)) begin
                        n_held_len = i_byte[LEN_W-1:0];
                        n_crc      = w_crc_upd;
                    end
                end
                PH_PAYLOAD: begin
                    w_store_we   = 1'b1;
                    n_crc        = w_crc_upd;
                    n_byte_index = r_byte_index + 1'b1;
                end
                PH_CRC_LO:  n_crc_low = i_byte;
                PH_CRC_HI:  o_hit     = w_crc_match;
                default: begin
                end
            endcase
        end
    end

    // assemble frame, bytes beyond the length read as zero
    always_comb begin
        o_frame.frame_type    = r_held_type;
        o_frame.frame_len     = r_held_len;
        o_frame.frame_payload = '0;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (LEN_W'(k) < r_held_len) begin
                o_frame.frame_payload[k*BYTE_W +: BYTE_W] = r_store[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_held_type  <= '0;
            r_held_len   <= '0;
            r_byte_index <= '0;
            r_crc_low    <= '0;
            r_crc        <= CRC_INIT;
        end else begin
            r_phase      <= n_phase;
            r_held_type  <= n_held_type;
            r_held_len   <= n_held_len;
            r_byte_index <= n_byte_index;
            r_crc_low    <= n_crc_low;
            r_crc        <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_byte_index[IDX_W-1:0]] <= i_byte;
        end
    end

`ifndef SYNTHESIS
    a_hit_only_on_crc_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> (i_step && r_phase == PH_CRC_HI))
        else $error("frame result outside crc high byte");
    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_len <= LEN_W'(MAX_PAYLOAD))
        else $error("held length above max payload");
    a_index_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_byte_index < r_held_len))
        else $error("payload index ran past length");
    a_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_CRC_HI) |=> (r_phase == PH_HUNT))
        else $error("parser did not return to hunt after crc");
`endif

endmodule

// ===== rtl/core/sync_frame_parser_crc16.sv =====
// top level of the sync frame parser with crc-16 check
//
// takes one received byte per transfer on i_rx and hunts for the sync pair
// 0xaa 0x55, followed by a type byte, a length byte (0 to 8), the payload
// and a little-endian crc-16 (reflected, poly 0xa001, init 0) over type,
// length and payload. a frame whose crc matches gives one transfer on
// o_frame carrying type, length and payload (first byte in bits 7:0, bytes
// beyond the length zero); bad sync, oversized length and crc mismatch
// give nothing. one byte is taken per cycle unless a held frame blocks the
// parser: the input register feeds the parser, whose crc update is a single
// unrolled 8-bit step, and the result register holds a finished frame until
// it is read. a byte waits in the input register until the parser steps on
// it; a frame is offered from the edge at which its last crc byte is parsed.
// the parser only steps while the result register could take a frame, so a
// full input register stalls the input while a held frame is not read.
module sync_frame_parser_crc16 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfp_in_if.sink    i_rx,
    sfp_out_if.source o_frame
);
    import sfp_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // result register
    logic              r_out_valid;
    t_frame            r_out_frame;

    logic              w_out_free;
    logic              w_step;
    logic              w_in_take;
    logic              w_hit;
    t_frame            w_frame;

    // result register can load when empty or when its frame leaves now
    assign w_out_free = !r_out_valid || o_frame.ready;
    // parser consumes the held byte whenever a result would have room
    assign w_step     = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_step;
    assign w_in_take  = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_hit   (w_hit),
        .o_frame (w_frame)
    );

    // a new frame takes the slot; otherwise a read transfer empties it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_hit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_hit) begin
            r_out_frame <= w_frame;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.frame_type    = r_out_frame.frame_type;
    assign o_frame.frame_len     = r_out_frame.frame_len;
    assign o_frame.frame_payload = r_out_frame.frame_payload;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |-> !w_step)
        else $error("parser stepped while result register was blocked");
    a_held_byte_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost before parsing");
    a_frame_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_hit) |=> r_out_valid)
        else $error("validated frame not presented");
`endif

endmodule

// ===== test/sync_frame_parser_crc16_test.sv =====
// self-checking testbench for the sync frame parser with crc-16 check
module sync_frame_parser_crc16_test;
    import sfp_pkg::*;

    // no transfer on either side for this many cycles ends the run
    localparam int WATCHDOG_LIMIT = 4000;
    // length of the forced output stall
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BYTE_TARGET = 1750;
    localparam int IDLE_PERCENT = 12;

    logic i_clk;
    logic i_rst_n;

    sfp_in_if  rx_if ();
    sfp_out_if frame_if ();

    sync_frame_parser_crc16 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if)
    );

    // bytes still to be offered, and frames the parser owes us
    logic [BYTE_W-1:0] byte_backlog_q[$];
    t_frame            frames_due_q[$];

    // shadow copy of the parser state
    t_phase            shadow_phase;
    logic [BYTE_W-1:0] shadow_type;
    logic [LEN_W-1:0]  shadow_len;
    logic [LEN_W-1:0]  shadow_count;
    logic [BYTE_W-1:0] shadow_payload[STORE_DEPTH];
    logic [BYTE_W-1:0] shadow_crc_lo;
    logic [CRC_W-1:0]  shadow_crc;

    int  bytes_sent;
    int  frames_checked;
    int  mismatch_count;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;

    // reflected crc-16, data bits folded in lsb first
    function automatic logic [CRC_W-1:0] fold_crc_byte(logic [CRC_W-1:0] acc,
                                                       logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = acc;
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[0] ^ data[i]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // queue a complete frame, optionally with a damaged crc
    function automatic void push_frame(logic [BYTE_W-1:0] ftype, logic [LEN_W-1:0] len,
                                       logic [PAYLOAD_W-1:0] pay, bit bad_crc);
        logic [CRC_W-1:0] crc;
        crc = fold_crc_byte(CRC_INIT, ftype);
        crc = fold_crc_byte(crc, {4'h0, len});
        byte_backlog_q.push_back(SYNC_FIRST);
        byte_backlog_q.push_back(SYNC_SECOND);
        byte_backlog_q.push_back(ftype);
        byte_backlog_q.push_back({4'h0, len});
        for (int k = 0; k < len; k++) begin
            byte_backlog_q.push_back(pay[8*k +: 8]);
            crc = fold_crc_byte(crc, pay[8*k +: 8]);
        end
        if (bad_crc) begin
            crc = crc ^ (16'h1 << $urandom_range(CRC_W - 1));
        end
        byte_backlog_q.push_back(crc[7:0]);
        byte_backlog_q.push_back(crc[15:8]);
    endfunction

    // advance the shadow parser by one accepted byte, queue a frame on crc match
    function automatic void advance_parser(logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0]     next_count;
        logic [PAYLOAD_W-1:0] word;
        t_frame               fr;
        case (shadow_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) shadow_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) shadow_phase = PH_TYPE;
                else if (b != SYNC_FIRST) shadow_phase = PH_HUNT;
            end
            PH_TYPE: begin
                shadow_type  = b;
                shadow_crc   = fold_crc_byte(CRC_INIT, b);
                shadow_phase = PH_LEN;
            end
            PH_LEN: begin
                shadow_count = '0;
                if (b > MAX_PAYLOAD) begin
                    // oversized length: frame dropped without a trace
                    shadow_phase = PH_HUNT;
                end else begin
                    shadow_len   = b[LEN_W-1:0];
                    shadow_crc   = fold_crc_byte(shadow_crc, b);
                    shadow_phase = (b != 0) ? PH_PAYLOAD : PH_CRC_LO;
                end
            end
            PH_PAYLOAD: begin
                shadow_payload[shadow_count[IDX_W-1:0]] = b;
                shadow_crc   = fold_crc_byte(shadow_crc, b);
                next_count   = shadow_count + 1'b1;
                shadow_count = next_count;
                if (next_count >= shadow_len) shadow_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                shadow_crc_lo = b;
                shadow_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                shadow_phase = PH_HUNT;
                if ({b, shadow_crc_lo} == shadow_crc) begin
                    word = '0;
                    for (int k = 0; k < STORE_DEPTH; k++) begin
                        if (k < shadow_len) word[8*k +: 8] = shadow_payload[k];
                    end
                    fr.frame_type    = shadow_type;
                    fr.frame_len     = shadow_len;
                    fr.frame_payload = word;
                    frames_due_q.push_back(fr);
                end
            end
            default: begin
                shadow_phase = PH_HUNT;
            end
        endcase
    endfunction

    // clock, and every block input known from time zero
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        frame_if.ready = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // both sides run without idles over this stretch of the stream
    function automatic bit may_idle();
        return !(bytes_sent >= 400 && bytes_sent < 700) &&
               ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // sender: offers the next byte once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
        end else begin
            if (rx_if.valid && rx_if.ready) begin
                advance_parser(rx_if.rx_byte);
                bytes_sent <= bytes_sent + 1;
            end
            if (!rx_if.valid || rx_if.ready) begin
                if (byte_backlog_q.size() != 0 && !may_idle()) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= byte_backlog_q.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each frame transfer against the oldest frame owed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                if (frames_due_q.size() == 0) begin
                    $error("unexpected frame: type %0h len %0d payload %0h",
                           frame_if.frame_type, frame_if.frame_len,
                           frame_if.frame_payload);
                    mismatch_count++;
                end else begin
                    t_frame want;
                    want = frames_due_q.pop_front();
                    frames_checked++;
                    if (frame_if.frame_type !== want.frame_type) begin
                        $error("frame_type: expected %0h, got %0h",
                               want.frame_type, frame_if.frame_type);
                        mismatch_count++;
                    end
                    if (frame_if.frame_len !== want.frame_len) begin
                        $error("frame_len: expected %0d, got %0d",
                               want.frame_len, frame_if.frame_len);
                        mismatch_count++;
                    end
                    if (frame_if.frame_payload !== want.frame_payload) begin
                        $error("frame_payload: expected %h, got %h",
                               want.frame_payload, frame_if.frame_payload);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off mid-run so the result register and the
            // input register both fill and the input has to stall
            if (hold_left != 0) begin
                hold_left      <= hold_left - 1;
                frame_if.ready <= 1'b0;
            end else if (!hold_done && bytes_sent >= 1000) begin
                hold_done      <= 1'b1;
                hold_left      <= HOLD_OFF_CYCLES;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= !may_idle();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_frame_parser_crc16_test: done, errors");
            $finish;
        end
    end

    initial begin
        int pick;
        int len;
        int cut;
        logic [PAYLOAD_W-1:0] pay;

        shadow_phase   = PH_HUNT;
        shadow_type    = '0;
        shadow_len     = '0;
        shadow_count   = '0;
        shadow_crc_lo  = '0;
        shadow_crc     = '0;
        for (int k = 0; k < STORE_DEPTH; k++) shadow_payload[k] = '0;
        bytes_sent     = 0;
        frames_checked = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        hold_left      = 0;
        hold_done      = 1'b0;

        // directed: repeated first sync into a zero-length frame, lowest type
        byte_backlog_q.push_back(SYNC_FIRST);
        push_frame(8'h00, 4'd0, '0, 1'b0);
        // wrong second sync byte
        byte_backlog_q.push_back(SYNC_FIRST);
        byte_backlog_q.push_back(8'h12);
        // length one above the maximum
        byte_backlog_q.push_back(SYNC_FIRST);
        byte_backlog_q.push_back(SYNC_SECOND);
        byte_backlog_q.push_back(8'h5A);
        byte_backlog_q.push_back(8'(MAX_PAYLOAD + 1));
        // crc mismatch on an all-ones frame
        push_frame(8'hFF, 4'd1, 64'hFF, 1'b1);

        // random: mostly good frames, mixed with damage and noise
        while (byte_backlog_q.size() < BYTE_TARGET) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(3) == 0) ? MAX_PAYLOAD : $urandom_range(MAX_PAYLOAD);
            pay  = {$urandom, $urandom};
            if (pick < 70) begin
                push_frame(8'($urandom), 4'(len), pay, 1'b0);
            end else if (pick < 80) begin
                push_frame(8'($urandom), 4'(len), pay, 1'b1);
            end else if (pick < 87) begin
                byte_backlog_q.push_back(SYNC_FIRST);
                byte_backlog_q.push_back(SYNC_SECOND);
                byte_backlog_q.push_back(8'($urandom));
                byte_backlog_q.push_back(8'($urandom_range(255, MAX_PAYLOAD + 1)));
            end else if (pick < 93) begin
                repeat ($urandom_range(6, 1)) begin
                    byte_backlog_q.push_back(($urandom_range(3) == 0) ? SYNC_FIRST
                                                                       : 8'($urandom));
                end
            end else if (pick < 97) begin
                // broken sync: first byte then a byte below the second
                byte_backlog_q.push_back(SYNC_FIRST);
                byte_backlog_q.push_back(8'($urandom_range(SYNC_SECOND - 1)));
            end else begin
                // truncated frame, the following bytes get swallowed as payload
                cut = $urandom_range(MAX_PAYLOAD - 1);
                byte_backlog_q.push_back(SYNC_FIRST);
                byte_backlog_q.push_back(SYNC_SECOND);
                byte_backlog_q.push_back(8'($urandom));
                byte_backlog_q.push_back(8'(MAX_PAYLOAD));
                repeat (cut) byte_backlog_q.push_back(8'($urandom));
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_backlog_q.size() != 0 || rx_if.valid) @(posedge i_clk);
        while (frames_due_q.size() != 0) @(posedge i_clk);
        // then idle on to catch any stray frame
        repeat (16) @(posedge i_clk);

        $display("streamed %0d bytes with sync faults, oversized lengths and crc damage",
                 bytes_sent);
        $display("compared %0d frames, %0d mismatches", frames_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("sync_frame_parser_crc16_test: done, clean");
        end else begin
            $display("sync_frame_parser_crc16_test: done, errors");
        end
        $finish;
    end

endmodule
